// File: design/equatorial_to_galactic_converter_defines.svh
// Assertion macros for the equatorial to galactic converter.
// Included by the modules that assert; expects clk and rst_n in scope.
`ifndef EQUATORIAL_TO_GALACTIC_CONVERTER_DEFINES_SVH
`define EQUATORIAL_TO_GALACTIC_CONVERTER_DEFINES_SVH

// same-cycle implication
`define ECG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ecg: same-cycle property violated");

// next-cycle implication
`define ECG_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ecg: next-cycle property violated");

`endif

// File: design/ecg_pkg.sv
// Shared types, constants and arithmetic helpers of the coordinate converter.
// No dependencies; the interface and module files import this package.
package ecg_pkg;

    localparam int ANGLE_FRAC_BITS = 22;
    localparam int CORDIC_STEPS    = 24;
    localparam int ISQRT_STEPS     = 32;

    localparam int QW = 34;   // Q30 values
    localparam int CW = 36;   // CORDIC datapath

    typedef logic        [30:0]   angle_t;
    typedef logic signed [29:0]   dec_t;
    typedef logic signed [30:0]   sangle_t;
    typedef logic signed [QW-1:0] q30_t;
    typedef logic signed [CW-1:0] cw_t;

    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctl_t;

    localparam logic [1:0] REG_POLE_RA  = 2'd0;
    localparam logic [1:0] REG_POLE_DEC = 2'd1;
    localparam logic [1:0] REG_NODE     = 2'd2;

    localparam angle_t FULL_TURN    = 31'(64'd360 << ANGLE_FRAC_BITS);
    localparam angle_t HALF_TURN    = 31'(64'd180 << ANGLE_FRAC_BITS);
    localparam angle_t QUARTER_TURN = 31'(64'd90 << ANGLE_FRAC_BITS);

    localparam angle_t RESET_POLE_RA = (ANGLE_FRAC_BITS >= 22)
        ? 31'(64'd808911293 << (ANGLE_FRAC_BITS - 22))
        : 31'(64'd808911293 >> (22 - ANGLE_FRAC_BITS));
    localparam dec_t RESET_POLE_DEC = (ANGLE_FRAC_BITS >= 22)
        ? 30'(64'd113784132 << (ANGLE_FRAC_BITS - 22))
        : 30'(64'd113784132 >> (22 - ANGLE_FRAC_BITS));
    localparam angle_t RESET_NODE = (ANGLE_FRAC_BITS >= 22)
        ? 31'(64'd515613838 << (ANGLE_FRAC_BITS - 22))
        : 31'(64'd515613838 >> (22 - ANGLE_FRAC_BITS));

    localparam q30_t ONE_Q30     = 34'sd1073741824;
    localparam cw_t  HALF_PI_Q30 = 36'sd1686629713;
    localparam cw_t  GAIN_Q30    = 36'sd652032874;

    localparam logic [30:0] DEG_TO_RAD_K = 31'd1199381129;
    localparam logic [29:0] RAD_TO_DEG_K = 30'd961263669;
    localparam int D2R_SHIFT = ANGLE_FRAC_BITS + 6;
    localparam int R2D_SHIFT = 54 - ANGLE_FRAC_BITS;

    // arctan(2^-i) in Q30 radians
    function automatic cw_t atan_q30(input int i);
        cw_t r;
        case (i)
            0:       r = 36'sd843314857;
            1:       r = 36'sd497837829;
            2:       r = 36'sd263043837;
            3:       r = 36'sd133525159;
            4:       r = 36'sd67021687;
            5:       r = 36'sd33543516;
            6:       r = 36'sd16775851;
            7:       r = 36'sd8388437;
            8:       r = 36'sd4194283;
            9:       r = 36'sd2097149;
            10:      r = 36'sd1048576;
            default: r = (i <= 30) ? cw_t'(64'd1 << (30 - i)) : '0;
        endcase
        return r;
    endfunction

    // Q30 product, rounded half up
    function automatic q30_t mul_q30(input logic signed [31:0] a,
                                     input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b + 64'sd536870912;
        return q30_t'(p >>> 30);
    endfunction

endpackage

// File: design/ecg_if.sv
// Handshake channels of the converter: sky position in, galactic position out.
// Depends on ecg_pkg for field types.
interface ecg_pos_if import ecg_pkg::*; ();
    logic    valid;
    logic    ready;
    angle_t  right_ascension;
    dec_t    declination;

    modport source (output valid, right_ascension, declination, input ready);
    modport sink   (input valid, right_ascension, declination, output ready);
endinterface

interface ecg_gal_if import ecg_pkg::*; ();
    logic    valid;
    logic    ready;
    angle_t  galactic_longitude;
    dec_t    galactic_latitude;

    modport source (output valid, galactic_longitude, galactic_latitude, input ready);
    modport sink   (input valid, galactic_longitude, galactic_latitude, output ready);
endinterface

// File: design/equatorial_to_galactic_converter.sv
// Throughput: one request per cycle; the whole pipeline advances on one enable,
// which drops only while a finished result waits at a stalled output.
// Reset (rst_n, async, active low) empties the pipeline and loads the J2000
// pole and node into the configuration registers.
module equatorial_to_galactic_converter import ecg_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [1:0]       wr_index,
    input  logic [30:0]      wr_data,
    ecg_pos_if.sink          position,
    ecg_gal_if.source        galactic
);

`include "equatorial_to_galactic_converter_defines.svh"

    // D stages of x, y, arg delay that match the square root unit
    localparam int D = ISQRT_STEPS + 1;

    localparam logic signed [32:0] FULL_S    = 33'(FULL_TURN);
    localparam logic signed [32:0] HALF_S    = 33'(HALF_TURN);
    localparam logic signed [30:0] QTR31     = 31'(QUARTER_TURN);
    localparam dec_t               QUARTER_S = 30'(QUARTER_TURN);
    localparam logic [61:0]        R2D_HALF  = 62'(1) << (R2D_SHIFT - 1);

    // ------------------------------------------------------------------
    // Configuration registers; write only while the pipeline is empty (not enforced).
    // ------------------------------------------------------------------
    angle_t pole_ra_reg;
    dec_t   pole_dec_reg;
    angle_t node_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pole_ra_reg  <= RESET_POLE_RA;
            pole_dec_reg <= RESET_POLE_DEC;
            node_reg     <= RESET_NODE;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_POLE_RA:  pole_ra_reg  <= wr_data;
                REG_POLE_DEC: pole_dec_reg <= wr_data[29:0];
                REG_NODE:     node_reg     <= wr_data;
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Global stall: everything advances unless the output holds a result
    // that the sink has not taken.
    // ------------------------------------------------------------------
    logic      en;
    logic      out_valid_reg;
    pipe_ctl_t sc_ctl, sq_ctl, at_ctl;

    assign en             = !out_valid_reg || galactic.ready;
    assign position.ready = en;

    // ------------------------------------------------------------------
    // S0: clamp declinations, RA difference wrapped into [-180,180).
    // |ra - pole_ra| < 1.5 turns, so one add or subtract of a turn suffices.
    // ------------------------------------------------------------------
    logic signed [32:0] ra_diff;
    logic signed [32:0] da;
    sangle_t            dec_cl, pdec_cl;

    always_comb
    begin
        ra_diff = 33'($signed({2'b00, position.right_ascension}))
                - 33'($signed({2'b00, pole_ra_reg}));
        if (ra_diff >= HALF_S)
            da = ra_diff - FULL_S;
        else if (ra_diff < -HALF_S)
            da = ra_diff + FULL_S;
        else
            da = ra_diff;

        dec_cl = 31'(position.declination);
        if (dec_cl > QTR31)
            dec_cl = QTR31;
        else if (dec_cl < -QTR31)
            dec_cl = -QTR31;

        pdec_cl = 31'(pole_dec_reg);
        if (pdec_cl > QTR31)
            pdec_cl = QTR31;
        else if (pdec_cl < -QTR31)
            pdec_cl = -QTR31;
    end

    logic    s0_valid_reg;
    sangle_t s0_dec_reg, s0_pdec_reg, s0_da_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (en)
            s0_valid_reg <= position.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_dec_reg  <= dec_cl;
            s0_pdec_reg <= pdec_cl;
            s0_da_reg   <= da[30:0];
        end
    end

    // ------------------------------------------------------------------
    // Three sine/cosine pipelines in lockstep: source dec, pole dec, RA diff.
    // ------------------------------------------------------------------
    logic sc_vd, sc_vp, sc_va;
    q30_t cd, sd, cp, sp, ca, sa;

    assign sc_ctl = '{en: en, valid: s0_valid_reg};

    ecg_sincos u_sc_dec (
        .clk(clk), .rst_n(rst_n), .ctl(sc_ctl), .angle(s0_dec_reg),
        .out_valid(sc_vd), .cos_q(cd), .sin_q(sd)
    );

    ecg_sincos u_sc_pole (
        .clk(clk), .rst_n(rst_n), .ctl(sc_ctl), .angle(s0_pdec_reg),
        .out_valid(sc_vp), .cos_q(cp), .sin_q(sp)
    );

    ecg_sincos u_sc_ra (
        .clk(clk), .rst_n(rst_n), .ctl(sc_ctl), .angle(s0_da_reg),
        .out_valid(sc_va), .cos_q(ca), .sin_q(sa)
    );

    // ------------------------------------------------------------------
    // P1..P4: spherical rotation products, at most one multiplier level per stage.
    //   arg = sd*sp + (cd*ca)*cp          (sine of latitude)
    //   x   = sd*cp - (cd*ca)*sp,  y = cd*sa
    // ------------------------------------------------------------------
    logic p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg;
    q30_t p1_cdca_reg, p1_ss_reg, p1_y_reg, p1_scp_reg, p1_cp_reg, p1_sp_reg;
    q30_t p2_t1_reg, p2_t2_reg, p2_ss_reg, p2_scp_reg, p2_y_reg;
    q30_t p3_arg_reg, p3_x_reg, p3_y_reg;
    q30_t p4_arg_reg, p4_x_reg, p4_y_reg;
    logic [60:0] p4_sq_reg;

    q30_t               sum_arg;
    q30_t               arg_cl;
    logic signed [31:0] a32;
    logic signed [63:0] sq_full;

    always_comb
    begin
        sum_arg = p2_ss_reg + p2_t1_reg;
        if (sum_arg > ONE_Q30)
            arg_cl = ONE_Q30;
        else if (sum_arg < -ONE_Q30)
            arg_cl = -ONE_Q30;
        else
            arg_cl = sum_arg;
        a32     = p3_arg_reg[31:0];
        sq_full = a32 * a32;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg <= sc_vd & sc_vp & sc_va;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_cdca_reg <= mul_q30(cd[31:0], ca[31:0]);
            p1_ss_reg   <= mul_q30(sd[31:0], sp[31:0]);
            p1_y_reg    <= mul_q30(cd[31:0], sa[31:0]);
            p1_scp_reg  <= mul_q30(sd[31:0], cp[31:0]);
            p1_cp_reg   <= cp;
            p1_sp_reg   <= sp;

            p2_t1_reg   <= mul_q30(p1_cdca_reg[31:0], p1_cp_reg[31:0]);
            p2_t2_reg   <= mul_q30(p1_cdca_reg[31:0], p1_sp_reg[31:0]);
            p2_ss_reg   <= p1_ss_reg;
            p2_scp_reg  <= p1_scp_reg;
            p2_y_reg    <= p1_y_reg;

            p3_arg_reg  <= arg_cl;
            p3_x_reg    <= p2_scp_reg - p2_t2_reg;
            p3_y_reg    <= p2_y_reg;

            p4_sq_reg   <= sq_full[60:0];
            p4_arg_reg  <= p3_arg_reg;
            p4_x_reg    <= p3_x_reg;
            p4_y_reg    <= p3_y_reg;
        end
    end

    // ------------------------------------------------------------------
    // Cosine of latitude: isqrt(2^60 - arg^2); x, y, arg ride alongside.
    // ------------------------------------------------------------------
    logic        sq_valid;
    logic [31:0] cos_lat;
    logic [63:0] radicand;

    assign radicand = (64'd1 << 60) - {3'b000, p4_sq_reg};
    assign sq_ctl   = '{en: en, valid: p4_valid_reg};

    ecg_isqrt u_isqrt (
        .clk(clk), .rst_n(rst_n), .ctl(sq_ctl), .radicand(radicand),
        .out_valid(sq_valid), .root(cos_lat)
    );

    q30_t xd_reg   [D];
    q30_t yd_reg   [D];
    q30_t argd_reg [D];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xd_reg[0]   <= p4_x_reg;
            yd_reg[0]   <= p4_y_reg;
            argd_reg[0] <= p4_arg_reg;
            for (int j = 1; j < D; j++)
            begin
                xd_reg[j]   <= xd_reg[j-1];
                yd_reg[j]   <= yd_reg[j-1];
                argd_reg[j] <= argd_reg[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Two atan2 pipelines: latitude = atan2(arg, cos_lat),
    // longitude offset = atan2(y, x).
    // ------------------------------------------------------------------
    logic at_lat_v, at_lon_v;
    cw_t  z_lat, z_lon;

    assign at_ctl = '{en: en, valid: sq_valid};

    ecg_atan2 u_at_lat (
        .clk(clk), .rst_n(rst_n), .ctl(at_ctl),
        .x_in(cw_t'(cos_lat)), .y_in(cw_t'(argd_reg[D-1])),
        .out_valid(at_lat_v), .angle(z_lat)
    );

    ecg_atan2 u_at_lon (
        .clk(clk), .rst_n(rst_n), .ctl(at_ctl),
        .x_in(cw_t'(xd_reg[D-1])), .y_in(cw_t'(yd_reg[D-1])),
        .out_valid(at_lon_v), .angle(z_lon)
    );

    // ------------------------------------------------------------------
    // R1: radian magnitude times 180/pi.  R2: round, restore sign.
    // ------------------------------------------------------------------
    logic        r1_valid_reg, r2_valid_reg;
    logic        r1_neg_lat_reg, r1_neg_lon_reg;
    logic [61:0] r1_prod_lat_reg, r1_prod_lon_reg;
    sangle_t     r2_lat_reg, r2_lon_reg;

    cw_t         mag_lat, mag_lon;
    logic [61:0] rnd_lat, rnd_lon;
    sangle_t     d_lat, d_lon;

    always_comb
    begin
        mag_lat = z_lat[CW-1] ? -z_lat : z_lat;
        mag_lon = z_lon[CW-1] ? -z_lon : z_lon;
        rnd_lat = (r1_prod_lat_reg + R2D_HALF) >> R2D_SHIFT;
        rnd_lon = (r1_prod_lon_reg + R2D_HALF) >> R2D_SHIFT;
        d_lat   = $signed({1'b0, rnd_lat[29:0]});
        d_lon   = $signed({1'b0, rnd_lon[29:0]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_valid_reg <= 1'b0;
            r2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            r1_valid_reg <= at_lat_v & at_lon_v;
            r2_valid_reg <= r1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_neg_lat_reg  <= z_lat[CW-1];
            r1_neg_lon_reg  <= z_lon[CW-1];
            r1_prod_lat_reg <= 62'(mag_lat[31:0]) * 62'(RAD_TO_DEG_K);
            r1_prod_lon_reg <= 62'(mag_lon[31:0]) * 62'(RAD_TO_DEG_K);
            r2_lat_reg      <= r1_neg_lat_reg ? -d_lat : d_lat;
            r2_lon_reg      <= r1_neg_lon_reg ? -d_lon : d_lon;
        end
    end

    // ------------------------------------------------------------------
    // Output register: latitude clamp, longitude = node - offset mod 360.
    // node - offset stays inside (-1, 2) turns, so one correction suffices.
    // ------------------------------------------------------------------
    sangle_t            lat_cl;
    logic signed [32:0] lon_raw;
    logic signed [32:0] lon_wrap;
    angle_t             lon_reg;
    dec_t               lat_reg;

    always_comb
    begin
        if (r2_lat_reg > QTR31)
            lat_cl = QTR31;
        else if (r2_lat_reg < -QTR31)
            lat_cl = -QTR31;
        else
            lat_cl = r2_lat_reg;

        lon_raw = 33'($signed({2'b00, node_reg})) - 33'(r2_lon_reg);
        if (lon_raw < 0)
            lon_wrap = lon_raw + FULL_S;
        else if (lon_raw >= FULL_S)
            lon_wrap = lon_raw - FULL_S;
        else
            lon_wrap = lon_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= r2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lat_reg <= lat_cl[29:0];
            lon_reg <= lon_wrap[30:0];
        end
    end

    assign galactic.valid              = out_valid_reg;
    assign galactic.galactic_longitude = lon_reg;
    assign galactic.galactic_latitude  = lat_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `ECG_ASSERT_IMP(a_lat_range, out_valid_reg, (lat_reg <= QUARTER_S) && (lat_reg >= -QUARTER_S))
    `ECG_ASSERT_IMP(a_lon_range, out_valid_reg, lon_reg < FULL_TURN)
    `ECG_ASSERT_NXT(a_stall_hold, !en, $stable(r2_valid_reg) && $stable(out_valid_reg))
    `ECG_ASSERT_NXT(a_accept_enters, position.valid && en, s0_valid_reg)

endmodule

// File: design/ecg_sincos.sv
// Pipelined sine/cosine of a degree angle: fold, degree to radian, rotation CORDIC.
// Depends on ecg_pkg.
module ecg_sincos import ecg_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  pipe_ctl_t ctl,
    input  sangle_t   angle,
    output logic      out_valid,
    output q30_t      cos_q,
    output q30_t      sin_q
);

    localparam logic signed [31:0] QTR = 32'(QUARTER_TURN);
    localparam logic [60:0] D2R_HALF = 61'(1) << (D2R_SHIFT - 1);

    logic signed [31:0] a_ext;
    logic signed [31:0] a_fold;
    logic               a_flip;
    logic        [31:0] a_abs;

    logic        va_reg, vb_reg;
    logic [29:0] mag_reg;
    logic        neg_a_reg, flip_a_reg, neg_b_reg, flip_b_reg;
    logic [60:0] prod_reg;
    logic [60:0] rnd;
    logic [31:0] r32;

    cw_t  x_reg [CORDIC_STEPS+1];
    cw_t  y_reg [CORDIC_STEPS+1];
    cw_t  z_reg [CORDIC_STEPS+1];
    logic f_reg [CORDIC_STEPS+1];
    logic v_reg [CORDIC_STEPS+1];

    logic vo_reg;
    q30_t cos_reg, sin_reg;

    // fold into [-90,90], remember the half-turn
    always_comb
    begin
        a_ext  = 32'(angle);
        a_flip = 1'b0;
        a_fold = a_ext;
        if (a_ext > QTR)
        begin
            a_fold = a_ext - (QTR <<< 1);
            a_flip = 1'b1;
        end
        else if (a_ext < -QTR)
        begin
            a_fold = a_ext + (QTR <<< 1);
            a_flip = 1'b1;
        end
        a_abs = a_fold[31] ? 32'(-a_fold) : 32'(a_fold);
        rnd   = (prod_reg + D2R_HALF) >> D2R_SHIFT;
        r32   = rnd[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            v_reg[0] <= 1'b0;
            vo_reg   <= 1'b0;
        end
        else if (ctl.en)
        begin
            va_reg   <= ctl.valid;
            vb_reg   <= va_reg;
            v_reg[0] <= vb_reg;
            vo_reg   <= v_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            mag_reg    <= a_abs[29:0];
            neg_a_reg  <= a_fold[31];
            flip_a_reg <= a_flip;
            prod_reg   <= 61'(mag_reg) * 61'(DEG_TO_RAD_K);
            neg_b_reg  <= neg_a_reg;
            flip_b_reg <= flip_a_reg;
            x_reg[0]   <= GAIN_Q30;
            y_reg[0]   <= '0;
            z_reg[0]   <= neg_b_reg ? -cw_t'(r32) : cw_t'(r32);
            f_reg[0]   <= flip_b_reg;
            cos_reg    <= f_reg[CORDIC_STEPS] ? q30_t'(-x_reg[CORDIC_STEPS])
                                              : q30_t'(x_reg[CORDIC_STEPS]);
            sin_reg    <= f_reg[CORDIC_STEPS] ? q30_t'(-y_reg[CORDIC_STEPS])
                                              : q30_t'(y_reg[CORDIC_STEPS]);
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        localparam cw_t ATAN = atan_q30(i);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (ctl.en)
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                f_reg[i+1] <= f_reg[i];
                if (!z_reg[i][CW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN;
                end
            end
        end
    end

    assign out_valid = vo_reg;
    assign cos_q     = cos_reg;
    assign sin_q     = sin_reg;

endmodule

// File: design/ecg_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on ecg_pkg.
module ecg_isqrt import ecg_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  pipe_ctl_t   ctl,
    input  logic [63:0] radicand,
    output logic        out_valid,
    output logic [31:0] root
);

    logic [63:0] n_reg [ISQRT_STEPS+1];
    logic [63:0] r_reg [ISQRT_STEPS+1];
    logic        v_reg [ISQRT_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (ctl.en)
            v_reg[0] <= ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            n_reg[0] <= radicand;
            r_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < ISQRT_STEPS; k++)
    begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] trial;

        assign trial = r_reg[k] + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else if (ctl.en)
                v_reg[k+1] <= v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                if (n_reg[k] >= trial)
                begin
                    n_reg[k+1] <= n_reg[k] - trial;
                    r_reg[k+1] <= (r_reg[k] >> 1) + BIT;
                end
                else
                begin
                    n_reg[k+1] <= n_reg[k];
                    r_reg[k+1] <= r_reg[k] >> 1;
                end
            end
        end
    end

    assign out_valid = v_reg[ISQRT_STEPS];
    assign root      = r_reg[ISQRT_STEPS][31:0];

endmodule

// File: design/ecg_atan2.sv
// Pipelined atan2 by vectoring CORDIC with quadrant pre-rotation.
// Depends on ecg_pkg.
module ecg_atan2 import ecg_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  pipe_ctl_t ctl,
    input  cw_t       x_in,
    input  cw_t       y_in,
    output logic      out_valid,
    output cw_t       angle
);

    cw_t  x_pre, y_pre, z_pre;

    cw_t  x_reg [CORDIC_STEPS+1];
    cw_t  y_reg [CORDIC_STEPS+1];
    cw_t  z_reg [CORDIC_STEPS+1];
    logic zero_reg [CORDIC_STEPS+1];
    logic v_reg [CORDIC_STEPS+1];

    logic vo_reg;
    cw_t  angle_reg;

    // left half-plane: rotate by a quarter turn first
    always_comb
    begin
        x_pre = x_in;
        y_pre = y_in;
        z_pre = '0;
        if (x_in[CW-1])
        begin
            if (!y_in[CW-1])
            begin
                x_pre = y_in;
                y_pre = -x_in;
                z_pre = HALF_PI_Q30;
            end
            else
            begin
                x_pre = -y_in;
                y_pre = x_in;
                z_pre = -HALF_PI_Q30;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
            vo_reg   <= 1'b0;
        end
        else if (ctl.en)
        begin
            v_reg[0] <= ctl.valid;
            vo_reg   <= v_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            x_reg[0]    <= x_pre;
            y_reg[0]    <= y_pre;
            z_reg[0]    <= z_pre;
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            angle_reg   <= zero_reg[CORDIC_STEPS] ? '0 : z_reg[CORDIC_STEPS];
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        localparam cw_t ATAN = atan_q30(i);
        logic y_pos;

        assign y_pos = !y_reg[i][CW-1] && (y_reg[i] != '0);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (ctl.en)
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_pos)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN;
                end
            end
        end
    end

    assign out_valid = vo_reg;
    assign angle     = angle_reg;

endmodule
